// ===== design/adjacency_edge_store_top_macros.svh =====
// Assertion macros for the adjacency edge store.
// Used by adjacency_edge_store_top; expects clk and rst_n in scope.
`ifndef ADJACENCY_EDGE_STORE_TOP_MACROS_SVH
`define ADJACENCY_EDGE_STORE_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ADJES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define ADJES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/adjes_pkg.sv =====
`timescale 1ns / 1ps
// Package for the adjacency edge store: transaction types, codes, states.
// No dependencies.
package adjes_pkg;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] STATUS_ADDED     = 2'd0;
    localparam logic [1:0] STATUS_DELETED   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] src_vertex;
        logic [7:0] dst_vertex;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  edge_slot;
        logic [10:0] edges_used;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== design/adjes_head_table.sv =====
`timescale 1ns / 1ps
// Head pointer memory, one entry {valid, slot} per vertex, with clearing sweep.
// Depends on nothing beyond its parameters.
module adjes_head_table #(
    parameter int VERTEX_COUNT = 256,
    parameter int SLOT_W       = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(VERTEX_COUNT)-1:0] rd_addr,
    output logic [SLOT_W:0]                 rd_entry,
    input  logic                            wr_en,
    input  logic [$clog2(VERTEX_COUNT)-1:0] wr_addr,
    input  logic [SLOT_W:0]                 wr_entry,
    output logic                            busy
);

    localparam int VW = $clog2(VERTEX_COUNT);

    logic [SLOT_W:0] mem [VERTEX_COUNT];
    logic [VW-1:0]   clr_idx_reg;
    logic [VW-1:0]   clr_idx_next;
    logic            busy_reg;
    logic            busy_next;
    logic [SLOT_W:0] rd_entry_reg;
    logic            mem_we;
    logic [VW-1:0]   mem_waddr;
    logic [SLOT_W:0] mem_wdata;

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == VW'(VERTEX_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
        end
        mem_we    = busy_reg || wr_en;
        mem_waddr = busy_reg ? clr_idx_reg : wr_addr;
        mem_wdata = busy_reg ? '0 : wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign busy     = busy_reg;

endmodule

// ===== design/adjacency_edge_store_top.sv =====
`timescale 1ns / 1ps
// Adjacency edge store: directed graph as per-vertex linked lists of edge slots.
// Depends on adjes_pkg, adjes_head_table and adjacency_edge_store_top_macros.svh.
//
// Input channel in_valid/in_stall/in_data carries one transaction per request:
// add an edge src->dst, or delete the newest edge src->dst. Output channel
// out_valid/out_stall/out_data returns exactly one result per request: status,
// the slot added or unlinked, and the number of slots allocated so far.
// One request is in work at a time. A rejected request goes straight to its
// result; an add reads the head entry and links a new slot at the head; a
// delete reads the head entry and then walks the list, newest edge first,
// until it matches or reaches the end; each step is one read of the edge
// memory. The next request can be accepted in the same cycle as the result.
// After reset the head table is cleared, one vertex a cycle, until every
// vertex is cleared; in_stall stays high during that sweep.
// The result sits in an output register: a new request is accepted while
// a result waits on out_stall, but that request does not finish until the
// output register is free.
// Slots are never reclaimed; once EDGE_SLOTS slots are used every add
// reports store full.
module adjacency_edge_store_top
    import adjes_pkg::*;
#(
    parameter int VERTEX_COUNT = 256,
    parameter int EDGE_SLOTS   = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    `include "adjacency_edge_store_top_macros.svh"

    localparam int VW = $clog2(VERTEX_COUNT);
    localparam int SW = $clog2(EDGE_SLOTS);
    localparam int CW = $clog2(EDGE_SLOTS + 1);
    localparam int EW = SW + 9;

    state_t          state_reg;
    state_t          state_next;
    logic            op_reg;
    logic            op_next;
    logic [7:0]      src_reg;
    logic [7:0]      src_next;
    logic [7:0]      dst_reg;
    logic [7:0]      dst_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [SW-1:0]   slot_res_reg;
    logic [SW-1:0]   slot_res_next;
    logic [SW-1:0]   cur_reg;
    logic [SW-1:0]   cur_next;
    logic [SW-1:0]   prev_reg;
    logic [SW-1:0]   prev_next;
    logic            prev_valid_reg;
    logic            prev_valid_next;
    logic [7:0]      prev_target_reg;
    logic [7:0]      prev_target_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    out_item_t       out_reg;
    out_item_t       out_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    logic [EW-1:0]   edge_mem [EDGE_SLOTS];
    logic [EW-1:0]   edge_rd_reg;
    logic [SW-1:0]   edge_rd_addr;
    logic            edge_wr_en;
    logic [SW-1:0]   edge_wr_addr;
    logic [EW-1:0]   edge_wr_data;

    logic [VW-1:0]   head_rd_addr;
    logic [SW:0]     head_rd_entry;
    logic            head_wr_en;
    logic [SW:0]     head_wr_entry;
    logic            head_busy;

    logic [31:0]     in_src_wide;
    logic [31:0]     in_dst_wide;
    logic [31:0]     src_wide;
    logic [31:0]     slot_wide;
    logic [31:0]     count_wide;
    logic            in_accept;
    logic            src_ok;
    logic            dst_ok;
    logic            full;
    logic            head_v;
    logic [SW-1:0]   head_s;
    logic            e_nv;
    logic [SW-1:0]   e_ns;
    logic [7:0]      e_t;
    logic            out_free;

    adjes_head_table #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .SLOT_W      (SW)
    ) u_head_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (head_rd_addr),
        .rd_entry(head_rd_entry),
        .wr_en   (head_wr_en),
        .wr_addr (src_wide[VW-1:0]),
        .wr_entry(head_wr_entry),
        .busy    (head_busy)
    );

    always_ff @(posedge clk)
    begin
        if (edge_wr_en)
        begin
            edge_mem[edge_wr_addr] <= edge_wr_data;
        end
        edge_rd_reg <= edge_mem[edge_rd_addr];
    end

    always_comb
    begin
        in_src_wide = 32'(in_data.src_vertex);
        in_dst_wide = 32'(in_data.dst_vertex);
        src_wide    = 32'(src_reg);
        slot_wide   = 32'(slot_res_reg);
        count_wide  = 32'(count_reg);
        in_stall    = head_busy || (state_reg != ST_IDLE);
        in_accept   = in_valid && !in_stall;
        src_ok      = in_src_wide < VERTEX_COUNT;
        dst_ok      = in_dst_wide < VERTEX_COUNT;
        full        = count_reg == CW'(EDGE_SLOTS);
        head_v      = head_rd_entry[SW];
        head_s      = head_rd_entry[SW-1:0];
        e_nv        = edge_rd_reg[EW-1];
        e_ns        = edge_rd_reg[EW-2:8];
        e_t         = edge_rd_reg[7:0];
        out_free    = !out_valid_reg || !out_stall;

        state_next       = state_reg;
        op_next          = op_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        status_next      = status_reg;
        slot_res_next    = slot_res_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        prev_valid_next  = prev_valid_reg;
        prev_target_next = prev_target_reg;
        count_next       = count_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && out_stall;

        head_rd_addr  = (state_reg == ST_IDLE) ? in_src_wide[VW-1:0] : src_wide[VW-1:0];
        head_wr_en    = 1'b0;
        head_wr_entry = {1'b1, count_reg[SW-1:0]};
        edge_rd_addr  = cur_reg;
        edge_wr_en    = 1'b0;
        edge_wr_addr  = count_reg[SW-1:0];
        edge_wr_data  = {head_v, head_s, dst_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = in_data.operation;
                    src_next      = in_data.src_vertex;
                    dst_next      = in_data.dst_vertex;
                    slot_res_next = '0;
                    if (in_data.operation == OP_ADD && (!src_ok || !dst_ok || full))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = ST_DONE;
                    end
                    else if (in_data.operation == OP_DELETE && !src_ok)
                    begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD:
            begin
                edge_rd_addr = head_s;
                if (op_reg == OP_ADD)
                begin
                    edge_wr_en    = 1'b1;
                    head_wr_en    = 1'b1;
                    count_next    = count_reg + 1'b1;
                    status_next   = STATUS_ADDED;
                    slot_res_next = count_reg[SW-1:0];
                    state_next    = ST_DONE;
                end
                else if (!head_v)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cur_next        = head_s;
                    prev_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK:
            begin
                edge_rd_addr = e_ns;
                if (e_t == dst_reg)
                begin
                    if (prev_valid_reg)
                    begin
                        edge_wr_en   = 1'b1;
                        edge_wr_addr = prev_reg;
                        edge_wr_data = {e_nv, e_ns, prev_target_reg};
                    end
                    else
                    begin
                        head_wr_en    = 1'b1;
                        head_wr_entry = {e_nv, e_ns};
                    end
                    status_next   = STATUS_DELETED;
                    slot_res_next = cur_reg;
                    state_next    = ST_DONE;
                end
                else if (!e_nv)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    prev_next        = cur_reg;
                    prev_target_next = e_t;
                    prev_valid_next  = 1'b1;
                    cur_next         = e_ns;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.status     = status_reg;
                    out_next.edge_slot  = slot_wide[9:0];
                    out_next.edges_used = count_wide[10:0];
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        status_reg      <= status_next;
        slot_res_reg    <= slot_res_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        prev_valid_reg  <= prev_valid_next;
        prev_target_reg <= prev_target_next;
        out_reg         <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ADJES_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_reg) <= EDGE_SLOTS,
        "slot count beyond store size")
    `ADJES_ASSERT_NEXT(a_add_allocates, (state_reg == ST_HEAD) && (op_reg == OP_ADD),
        count_reg == CW'(32'($past(count_reg)) + 1), "add did not allocate one slot")
    `ADJES_ASSERT_NEXT(a_done_delivers, (state_reg == ST_DONE) && !(out_valid && out_stall),
        out_valid && (state_reg == ST_IDLE), "finished result not delivered")

endmodule
